>>> hdl/aesd_pkg.sv
// ----------------------------------------------------------------------------
// AES decrypt package
// Shared constants, types and GF(2^8) helper functions for the AES decryptor.
// ----------------------------------------------------------------------------
package aesd_pkg;

    localparam int KEY_ROUNDS_MAX = 15;
    localparam int STORE_DEPTH    = 2 * KEY_ROUNDS_MAX;
    localparam int SLOT_W         = $clog2(STORE_DEPTH);
    localparam int ROUND_W        = $clog2(KEY_ROUNDS_MAX);

    localparam logic [1:0] ACT_KEY = 2'd0;
    localparam logic [1:0] ACT_IV  = 2'd1;
    localparam logic [1:0] ACT_DEC = 2'd2;

    localparam logic [1:0] CFG_KEY_SIZE = 2'd0;
    localparam logic [1:0] CFG_CHAIN    = 2'd1;

    localparam logic [1:0] CHAIN_CBC  = 2'd1;
    localparam logic [1:0] CHAIN_PCBC = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_FIRST,
        ST_ROUND,
        ST_DONE
    } t_state;

    // Input and output payloads.
    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  key_slot;
        logic [63:0] data_hi;
        logic [63:0] data_lo;
    } t_in;

    typedef struct packed {
        logic [63:0] plain_hi;
        logic [63:0] plain_lo;
    } t_out;

    typedef struct packed {
        logic [1:0] index;
        logic [1:0] value;
    } t_cfg;

    // Controls from the sequencer to the round datapath.
    typedef struct packed {
        logic load;
        logic first;
        logic step;
        logic last;
    } t_round_ctl;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] p;
        acc = 8'h00;
        p   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc = acc ^ p;
            p = xtime(p);
        end
        gmul = acc;
    endfunction

    function automatic logic [7:0] inv_sub(input logic [7:0] y);
        logic [7:0] x;
        logic [7:0] r;
        logic [7:0] p;
        x = {y[6:0], y[7]} ^ {y[4:0], y[7:5]} ^ {y[1:0], y[7:2]} ^ 8'h05;
        r = 8'h01;
        p = x;
        for (int i = 0; i < 8; i++) begin
            if (i != 0) r = gmul(r, p);
            p = gmul(p, p);
        end
        inv_sub = r;
    endfunction

    // Inverse S-box as a constant table built at elaboration.
    function automatic logic [255:0][7:0] build_sbox();
        logic [255:0][7:0] t;
        for (int i = 0; i < 256; i++) t[i] = inv_sub(8'(i));
        build_sbox = t;
    endfunction

    localparam logic [255:0][7:0] INV_SBOX = build_sbox();

endpackage

>>> hdl/aesd_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel interface
// Generic handshake channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface aesd_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/aesd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module aesd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 30
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/aesd_round.sv
// ----------------------------------------------------------------------------
// AES inverse round unit
// One shared inverse round applied once per cycle to the state register while step is set.
// ----------------------------------------------------------------------------
module aesd_round
    import aesd_pkg::*;
(
    input  logic         i_clk,
    input  t_round_ctl   i_ctl,
    input  logic [127:0] i_block,
    input  logic [127:0] i_key,
    output logic [127:0] o_state
);
    logic [127:0] r_state;
    logic [127:0] n_state;
    logic [7:0]   s  [16];
    logic [7:0]   t  [16];
    logic [7:0]   m  [16];
    logic [127:0] ak;

    // InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns.
    always_comb begin
        for (int i = 0; i < 16; i++) s[i] = r_state[127-8*i -: 8];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[c*4+r] = INV_SBOX[s[((c - r) & 3) * 4 + r]];
            end
        end
        for (int i = 0; i < 16; i++) ak[127-8*i -: 8] = t[i] ^ i_key[127-8*i -: 8];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                m[c*4+r] = gmul(8'h0e, ak[127-8*(c*4+r)       -: 8])
                         ^ gmul(8'h0b, ak[127-8*(c*4+((r+1)&3)) -: 8])
                         ^ gmul(8'h0d, ak[127-8*(c*4+((r+2)&3)) -: 8])
                         ^ gmul(8'h09, ak[127-8*(c*4+((r+3)&3)) -: 8]);
            end
        end
        n_state = r_state;
        if (i_ctl.load) begin
            n_state = i_block;
        end else if (i_ctl.first) begin
            n_state = r_state ^ i_key;
        end else if (i_ctl.step) begin
            if (i_ctl.last) begin
                n_state = ak;
            end else begin
                for (int i = 0; i < 16; i++) n_state[127-8*i -: 8] = m[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
    end

    assign o_state = r_state;
endmodule

>>> hdl/aes_block_decrypt_chained.sv
// ----------------------------------------------------------------------------
// AES block decryptor with ECB, CBC and PCBC chaining
// Top level: sequencer, key store, round unit and output register.
// ----------------------------------------------------------------------------
// Usage: s_in carries transactions with an action. A key-load transaction
// writes one 64-bit round key half into the key store; an IV transaction
// loads the previous ciphertext and clears the previous plaintext. A
// decrypt transaction runs on a single shared round unit. Each of the
// Nr+1 key additions (Nr is 10, 12 or 14) first fetches the two round key
// halves through the single registered read port of the key store and
// then applies the round. A final step chains the block and writes the
// result into the output register. The input is not ready while a block
// is in flight or while a result waits in the output register, so no new
// transaction is accepted until the previous result has been taken.
// m_out holds its result until the receiver takes it; a stalled receiver
// simply holds the block off further input. s_cfg writes key_size_code
// (index 0) and chain_mode (index 1) and is always ready.
// Reset clears the chaining registers, configuration and control state.
// The key store has no reset; keys must be loaded before decrypting.
// ----------------------------------------------------------------------------
module aes_block_decrypt_chained
    import aesd_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    aesd_if.sink   s_cfg,
    aesd_if.sink   s_in,
    aesd_if.source m_out
);
    t_state       r_st, n_st;
    logic [1:0]   r_ksc, r_chain;
    logic [63:0]  r_pc_hi, r_pc_lo, r_pp_hi, r_pp_lo;
    logic [63:0]  r_ct_hi, r_ct_lo;
    logic [ROUND_W-1:0] r_round;
    logic         r_half;
    logic [63:0]  r_khi;
    logic [127:0] r_key;
    logic         r_kvalid;
    logic         r_ovalid;
    t_out         r_out;
    logic [SLOT_W-1:0] raddr;
    logic [63:0]  rdata;
    logic         acc_in;
    logic         we;
    t_round_ctl   ctl;
    logic [127:0] state;
    logic [ROUND_W-1:0] nr;
    logic [127:0] plain;
    t_in          din;
    t_cfg         cfg;

    assign din = s_in.data;
    assign cfg = s_cfg.data;
    assign s_cfg.ready = 1'b1;
    assign s_in.ready  = (r_st == ST_IDLE) && !r_ovalid;
    assign acc_in      = s_in.valid && s_in.ready;
    assign nr = (r_ksc == 2'd0) ? ROUND_W'(10) : (r_ksc == 2'd1) ? ROUND_W'(12) : ROUND_W'(14);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksc   <= '0;
            r_chain <= '0;
        end else if (s_cfg.valid) begin
            if (cfg.index == CFG_KEY_SIZE) r_ksc <= cfg.value;
            if (cfg.index == CFG_CHAIN)    r_chain <= cfg.value;
        end
    end

    // Key store.
    assign we = acc_in && (din.action == ACT_KEY) && (din.key_slot < 5'(STORE_DEPTH));
    assign raddr = SLOT_W'({r_round, r_half});

    aesd_ram #(.WIDTH(64), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(din.key_slot[SLOT_W-1:0]),
        .i_wdata(din.data_hi),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Next-state logic. FETCH reads two halves, then one round applies.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (acc_in && din.action == ACT_DEC) n_st = ST_FETCH;
            ST_FETCH: if (r_kvalid) n_st = (r_round == nr) ? ST_FIRST : ST_ROUND;
            ST_FIRST: n_st = ST_FETCH;
            ST_ROUND: n_st = (r_round == '0) ? ST_DONE : ST_FETCH;
            ST_DONE:  n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // Round unit controls.
    always_comb begin
        ctl       = '0;
        ctl.load  = acc_in && (din.action == ACT_DEC);
        ctl.first = (r_st == ST_FIRST);
        ctl.step  = (r_st == ST_ROUND);
        ctl.last  = (r_round == '0);
    end

    // Sequencer: round counter, key half select and key assembly.
    // Read address issued with half h; data arrives the following cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_round  <= '0;
            r_half   <= 1'b0;
            r_kvalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (ctl.load) begin
                r_round  <= nr;
                r_half   <= 1'b0;
                r_kvalid <= 1'b0;
            end else if (r_st == ST_FETCH) begin
                // FETCH issues the high half address, then the low half address while the
                // high half returns, and then sees the low half.
                if (!r_half) begin
                    r_half <= 1'b1;
                end else begin
                    r_kvalid <= 1'b1;
                end
            end else if (r_st == ST_FIRST || r_st == ST_ROUND) begin
                r_kvalid <= 1'b0;
                r_half   <= 1'b0;
                if (r_round != '0) r_round <= r_round - 1'b1;
            end
        end
    end

    // Capture halves: hi arrives when r_half is 1 first time, lo after.
    always_ff @(posedge i_clk) begin
        if (r_st == ST_FETCH && r_half && !r_kvalid) r_khi <= rdata;
        if (r_st == ST_FETCH && r_kvalid) r_key <= {r_khi, rdata};
    end

    aesd_round u_round (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_block({din.data_hi, din.data_lo}),
        .i_key  ((ctl.first || ctl.step) ? r_key : 128'd0),
        .o_state(state)
    );

    // Chaining of the finished block.
    always_comb begin
        plain = state;
        if (r_chain == CHAIN_CBC || r_chain == CHAIN_PCBC) plain = plain ^ {r_pc_hi, r_pc_lo};
        if (r_chain == CHAIN_PCBC) plain = plain ^ {r_pp_hi, r_pp_lo};
    end

    // Chaining registers, held ciphertext and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc_hi  <= '0;
            r_pc_lo  <= '0;
            r_pp_hi  <= '0;
            r_pp_lo  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (acc_in && din.action == ACT_IV) begin
                r_pc_hi <= din.data_hi;
                r_pc_lo <= din.data_lo;
                r_pp_hi <= '0;
                r_pp_lo <= '0;
            end
            if (r_st == ST_DONE) begin
                r_pc_hi  <= r_ct_hi;
                r_pc_lo  <= r_ct_lo;
                r_pp_hi  <= plain[127:64];
                r_pp_lo  <= plain[63:0];
                r_ovalid <= 1'b1;
            end else if (m_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load) begin
            r_ct_hi <= din.data_hi;
            r_ct_lo <= din.data_lo;
        end
        if (r_st == ST_DONE) begin
            r_out.plain_hi <= plain[127:64];
            r_out.plain_lo <= plain[63:0];
        end
    end

    assign m_out.valid = r_ovalid;
    assign m_out.data  = r_out;
endmodule

>>> hdl/aesd_checker.sv
// ----------------------------------------------------------------------------
// AES decryptor port checker
// Concurrent checks on the top-level channels.
// ----------------------------------------------------------------------------
module aesd_port_props
    import aesd_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input t_out out_data
);
    // A waiting result holds until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // No input is taken while a result waits.
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("input ready with pending result");

    // No result is valid straight after an input is accepted.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result too early");
endmodule

bind aes_block_decrypt_chained aesd_port_props u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_valid (s_in.valid),
    .in_ready (s_in.ready),
    .out_valid(m_out.valid),
    .out_ready(m_out.ready),
    .out_data (m_out.data)
);
